@@ rtl/csti_pkg.sv @@
// Package for the cross-section table interpolator: command and status codes,
// field widths and the eV-per-MeV scale. Used by every module in rtl/.
package csti_pkg;

    localparam int ENERGY_W = 30;
    localparam int VALUE_W  = 32;
    localparam int MEV_W    = 10;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    typedef logic [ENERGY_W-1:0] t_energy;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STAT_W-1:0]   t_status;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_BELOW = 3'd2;
    localparam t_status ST_ABOVE = 3'd3;
    localparam t_status ST_FULL  = 3'd4;

    localparam t_energy EV_PER_MEV = 30'd1000000;

endpackage

@@ rtl/cross_section_table_interpolator.sv @@
// Top level of the cross-section table interpolator: breakpoint memories, search
// sequencer and result register. Depends on csti_pkg and csti_muldiv.
//
// Usage
//   Command channel: an item is taken at a rising edge with start high and busy
//   low. i_command selects clear (0), append (1) or query (2); code 3 does nothing.
//   Result channel: every item gives one result beat, o_sigma and o_status held
//   for exactly one cycle with o_done high. There is no back-pressure: the
//   receiver must take each beat in the cycle it appears.
// Sequencing
//   Clear, append, unused code and a query on an empty table: the result beat
//   is registered and busy stays low, so a new item may be taken every cycle.
//   Query: busy rises for the search and the arithmetic. States S_RD0, S_CHK0
//   and S_CHKN read and check the first and last breakpoints (a query below
//   the first ends in S_CHK0, one above the last in S_CHKN); the scan then
//   visits one breakpoint per cycle, set by the single memory read port, up
//   to the first point above the query. That hit runs the bit-serial unit,
//   multiply then divide, and the result is formed when it is done. A query on
//   the last point ends the scan with the last point's value. The next item
//   may be taken at the edge that takes the result beat.
// Reset
//   Synchronous, active low: point count to zero, sequencer idle, no beat shown.
//   Memories are not cleared; only entries below the point count are used.
module cross_section_table_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  csti_pkg::t_cmd     i_command,
    input  csti_pkg::t_energy  i_point_energy,
    input  csti_pkg::t_value   i_point_value,
    input  logic [csti_pkg::MEV_W-1:0] i_query_mev,
    output logic               o_done,
    output csti_pkg::t_value   o_sigma,
    output csti_pkg::t_status  o_status
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);   // holds 0..TABLE_DEPTH
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;   // reading first point
    localparam logic [2:0] S_CHK0 = 3'd2;   // first point in, reading last
    localparam logic [2:0] S_CHKN = 3'd3;   // last point in, reading point 1
    localparam logic [2:0] S_SCAN = 3'd4;   // one breakpoint per cycle
    localparam logic [2:0] S_CALC = 3'd5;   // waiting on serial mul/div

    // breakpoint memories: one write and one registered read per cycle
    csti_pkg::t_energy  mem_e [TABLE_DEPTH];
    csti_pkg::t_value   mem_v [TABLE_DEPTH];

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;       // read address for the next edge
    logic [CW-1:0]      r_dix, n_dix;       // index of data now in r_rd_*
    csti_pkg::t_energy  r_e, n_e;           // query energy in eV
    csti_pkg::t_energy  r_pe, n_pe;         // previous point energy
    csti_pkg::t_value   r_pv, n_pv;         // previous point value
    csti_pkg::t_value   r_vlast, n_vlast;   // value of last point
    logic               r_up, n_up;         // rising segment
    csti_pkg::t_energy  r_rd_e;
    csti_pkg::t_value   r_rd_v;
    logic               r_done, n_done;
    csti_pkg::t_value   r_sigma, n_sigma;
    csti_pkg::t_status  r_status, n_status;

    logic               accept;
    logic               mem_we;
    logic               md_start;
    logic               md_done;
    csti_pkg::t_value   md_quot;
    csti_pkg::t_energy  seg_dx;
    csti_pkg::t_energy  seg_den;
    csti_pkg::t_value   seg_dv;
    logic               seg_up;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign mem_we = accept && (i_command == csti_pkg::CMD_APPEND) && (r_count != FULL_COUNT);

    // segment between previous point and the one just read
    assign seg_dx  = r_e - r_pe;
    assign seg_den = r_rd_e - r_pe;
    assign seg_up  = (r_rd_v >= r_pv);
    assign seg_dv  = seg_up ? (r_rd_v - r_pv) : (r_pv - r_rd_v);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_dix    = r_dix;
        n_e      = r_e;
        n_pe     = r_pe;
        n_pv     = r_pv;
        n_vlast  = r_vlast;
        n_up     = r_up;
        n_done   = 1'b0;
        n_sigma  = '0;
        n_status = csti_pkg::ST_OK;
        md_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        csti_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        csti_pkg::CMD_APPEND: begin
                            n_done = 1'b1;
                            if (r_count == FULL_COUNT) begin
                                n_status = csti_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        csti_pkg::CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = csti_pkg::ST_EMPTY;
                            end else begin
                                n_e     = 30'(30'(i_query_mev) * csti_pkg::EV_PER_MEV);
                                n_idx   = '0;
                                n_state = S_RD0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_RD0: begin
                n_idx   = r_count - CW'(1);
                n_state = S_CHK0;
            end
            S_CHK0: begin
                n_pe  = r_rd_e;
                n_pv  = r_rd_v;
                n_idx = CW'(1);
                if (r_e <= r_rd_e) begin
                    n_done   = 1'b1;
                    n_status = csti_pkg::ST_BELOW;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHKN;
                end
            end
            S_CHKN: begin
                n_vlast = r_rd_v;
                n_idx   = CW'(2);
                n_dix   = CW'(1);
                if (r_e > r_rd_e) begin
                    n_done   = 1'b1;
                    n_status = csti_pkg::ST_ABOVE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dix >= r_count) begin
                    // no stored energy above the query: last point's value
                    n_done  = 1'b1;
                    n_sigma = r_vlast;
                    n_state = S_IDLE;
                end else if (r_e < r_rd_e) begin
                    md_start = 1'b1;
                    n_up     = seg_up;
                    n_state  = S_CALC;
                end else begin
                    n_pe  = r_rd_e;
                    n_pv  = r_rd_v;
                    n_idx = r_idx + CW'(1);
                    n_dix = r_dix + CW'(1);
                end
            end
            S_CALC: begin
                if (md_done) begin
                    n_done  = 1'b1;
                    n_sigma = r_up ? (r_pv + md_quot) : (r_pv - md_quot);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx    <= n_idx;
        r_dix    <= n_dix;
        r_e      <= n_e;
        r_pe     <= n_pe;
        r_pv     <= n_pv;
        r_vlast  <= n_vlast;
        r_up     <= n_up;
        r_sigma  <= n_sigma;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_e[r_count[AW-1:0]] <= i_point_energy;
            mem_v[r_count[AW-1:0]] <= i_point_value;
        end
        r_rd_e <= mem_e[r_idx[AW-1:0]];
        r_rd_v <= mem_v[r_idx[AW-1:0]];
    end

    csti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_dx    (seg_dx),
        .i_den   (seg_den),
        .i_dv    (seg_dv),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    assign o_done   = r_done;
    assign o_sigma  = r_sigma;
    assign o_status = r_status;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("point count beyond table depth");
    a_sigma_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_sigma != '0) |-> o_status == csti_pkg::ST_OK)
        else $error("non-zero sigma with error status");
    a_busy_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && $past(i_command) == csti_pkg::CMD_QUERY))
        else $error("busy raised without a query beat");
    a_calc_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && md_done) |=> (o_done && r_state == S_IDLE))
        else $error("interpolation finished without a result beat");
`endif

endmodule

@@ rtl/csti_muldiv.sv @@
// Bit-serial unit: dx * dv by shift-and-add, then that product / den by restoring
// division, one bit per cycle. Depends on csti_pkg. Requires dx < den.
module csti_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  csti_pkg::t_energy  i_dx,
    input  csti_pkg::t_energy  i_den,
    input  csti_pkg::t_value   i_dv,
    output logic               o_done,
    output csti_pkg::t_value   o_quot
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]              r_phase, n_phase;
    logic [4:0]              r_cnt, n_cnt;
    logic                    r_done, n_done;
    csti_pkg::t_value        r_hi, n_hi;     // product high word
    csti_pkg::t_energy       r_lo, n_lo;     // multiplier bits, then product low bits
    csti_pkg::t_value        r_dv, n_dv;
    csti_pkg::t_energy       r_den, n_den;
    csti_pkg::t_energy       r_rem, n_rem;   // partial remainder
    csti_pkg::t_value        r_nq, n_nq;     // numerator bits in, quotient bits out

    logic [32:0]             mul_sum;
    logic [30:0]             div_trial;
    logic [30:0]             div_diff;

    assign mul_sum   = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_dv}) : {1'b0, r_hi};
    assign div_trial = {r_rem, r_nq[31]};
    assign div_diff  = div_trial - {1'b0, r_den};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_dv    = r_dv;
        n_den   = r_den;
        n_rem   = r_rem;
        n_nq    = r_nq;
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_hi    = '0;
                    n_lo    = i_dx;
                    n_dv    = i_dv;
                    n_den   = i_den;
                    n_cnt   = 5'd29;
                    n_phase = P_MUL;
                end
            end
            P_MUL: begin
                n_hi = mul_sum[32:1];
                n_lo = {mul_sum[0], r_lo[29:1]};
                if (r_cnt == 5'd0) begin
                    // product = {hi, lo}; top 30 bits seed the remainder
                    n_rem   = mul_sum[32:3];
                    n_nq    = {mul_sum[2:1], mul_sum[0], r_lo[29:1]};
                    n_cnt   = 5'd31;
                    n_phase = P_DIV;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            P_DIV: begin
                if (div_diff[30]) begin
                    n_rem = div_trial[29:0];
                    n_nq  = {r_nq[30:0], 1'b0};
                end else begin
                    n_rem = div_diff[29:0];
                    n_nq  = {r_nq[30:0], 1'b1};
                end
                if (r_cnt == 5'd0) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_dv  <= n_dv;
        r_den <= n_den;
        r_rem <= n_rem;
        r_nq  <= n_nq;
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

`ifndef NO_ASSERTIONS
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_phase) == P_DIV)
        else $error("muldiv done without a division step");
    a_start_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_MUL) |=> (r_phase == P_MUL || r_phase == P_DIV))
        else $error("muldiv left the multiply phase early");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_DIV) |-> r_rem < r_den)
        else $error("partial remainder not below divisor");
`endif

endmodule

@@ verif/tb_cross_section_table_interpolator.sv @@
// Self-checking testbench for cross_section_table_interpolator: directed beats, then
// randomised clear/append/query traffic checked against an in-bench interpolation predictor.
// Depends on csti_pkg and the RTL in rtl/.

typedef logic [csti_pkg::MEV_W-1:0] t_mev;

typedef struct packed {
    csti_pkg::t_value  sigma;
    csti_pkg::t_status status;
} t_sigma_beat;

// Mirror of the breakpoint store plus the queue of results still owed by the block.
class t_sigma_scoreboard;
    int unsigned       depth;
    csti_pkg::t_energy bp_energy[$];
    csti_pkg::t_value  bp_value[$];
    t_sigma_beat       pending_beats[$];
    int unsigned       mismatches;

    function new(int unsigned table_depth);
        depth      = table_depth;
        mismatches = 0;
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // First breakpoint above the query, linear step from the one before it.
    function t_sigma_beat lookup_sigma(t_mev mev);
        t_sigma_beat res;
        logic [31:0] ev;
        logic [63:0] dx, span, q;
        int          n, hit, j;
        res.sigma  = '0;
        res.status = csti_pkg::ST_OK;
        ev  = 32'(mev) * 32'(csti_pkg::EV_PER_MEV);
        n   = bp_energy.size();
        hit = 0;
        if (n == 0) begin
            res.status = csti_pkg::ST_EMPTY;
        end else if (ev <= 32'(bp_energy[0])) begin
            res.status = csti_pkg::ST_BELOW;
        end else if (ev > 32'(bp_energy[n-1])) begin
            res.status = csti_pkg::ST_ABOVE;
        end else begin
            for (j = 1; j < n && hit == 0; j++) begin
                if (ev < 32'(bp_energy[j])) hit = j;
            end
            if (hit == 0) begin
                // nothing above the query: it sits on the last breakpoint
                res.sigma = bp_value[n-1];
            end else begin
                dx   = 64'(ev) - 64'(bp_energy[hit-1]);
                span = 64'(bp_energy[hit]) - 64'(bp_energy[hit-1]);
                if (bp_value[hit] >= bp_value[hit-1]) begin
                    q = (dx * (64'(bp_value[hit]) - 64'(bp_value[hit-1]))) / span;
                    res.sigma = bp_value[hit-1] + q[31:0];
                end else begin
                    q = (dx * (64'(bp_value[hit-1]) - 64'(bp_value[hit]))) / span;
                    res.sigma = bp_value[hit-1] - q[31:0];
                end
            end
        end
        return res;
    endfunction

    function void note_command(csti_pkg::t_cmd cmd, csti_pkg::t_energy pe,
                               csti_pkg::t_value pv, t_mev mev);
        t_sigma_beat want;
        want.sigma  = '0;
        want.status = csti_pkg::ST_OK;
        case (cmd)
            csti_pkg::CMD_CLEAR: begin
                bp_energy.delete();
                bp_value.delete();
            end
            csti_pkg::CMD_APPEND: begin
                if (bp_energy.size() >= depth) begin
                    want.status = csti_pkg::ST_FULL;
                end else begin
                    bp_energy = {bp_energy, pe};
                    bp_value  = {bp_value, pv};
                end
            end
            csti_pkg::CMD_QUERY: want = lookup_sigma(mev);
            default: ;
        endcase
        pending_beats = {pending_beats, want};
    endfunction

    task check_beat(csti_pkg::t_value sigma, csti_pkg::t_status status);
        t_sigma_beat want;
        if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat sigma=%h status=%0d", sigma, status));
        end else begin
            want = pending_beats.pop_front();
            if (sigma !== want.sigma) begin
                report_mismatch($sformatf("sigma %h, wanted %h", sigma, want.sigma));
            end
            if (status !== want.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
            end
        end
    endtask

    task report_leftovers();
        if (pending_beats.size() != 0) begin
            report_mismatch($sformatf("%0d result beats never arrived", pending_beats.size()));
        end
    endtask
endclass

module tb_cross_section_table_interpolator;

    localparam int   TBL_DEPTH    = 256;
    localparam int   ITEM_BEATS   = 400;
    localparam int   MAX_GAP      = 17;
    // worst query: full scan plus the bit-serial multiply/divide
    localparam int   DRAIN_CYCLES = TBL_DEPTH + 80;
    localparam int   STALL_LIMIT  = 4 * (DRAIN_CYCLES + MAX_GAP);
    localparam csti_pkg::t_cmd CMD_UNUSED = 2'd3;   // decoded as a no-op by the block

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    csti_pkg::t_cmd    i_command      = csti_pkg::CMD_CLEAR;
    csti_pkg::t_energy i_point_energy = '0;
    csti_pkg::t_value  i_point_value  = '0;
    t_mev              i_query_mev    = '0;
    logic              busy;
    logic              o_done;
    csti_pkg::t_value  o_sigma;
    csti_pkg::t_status o_status;

    t_sigma_scoreboard sb;

    int   beats_sent;
    int   stall_cycles;
    bit   no_idle;       // set for whole sequences: back-to-back beats
    int   lo_mev;        // query aim window for the table just loaded
    int   hi_mev = 1023;
    int   exact_mev[$];  // breakpoints lying exactly on a whole MeV

    cross_section_table_interpolator #(
        .TABLE_DEPTH    (TBL_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_point_energy (i_point_energy),
        .i_point_value  (i_point_value),
        .i_query_mev    (i_query_mev),
        .o_done         (o_done),
        .o_sigma        (o_sigma),
        .o_status       (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result beats: one cycle wide, no back-pressure, so sample every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_beat(o_sigma, o_status);
        end
    end

    // Watchdog: any command or result beat resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // One command beat. start is only dropped when a gap is drawn, so a
    // back-to-back beat never sees start lowered and raised in one step.
    task automatic send_beat(csti_pkg::t_cmd cmd, csti_pkg::t_energy pe,
                             csti_pkg::t_value pv, t_mev mev);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_point_energy <= pe;
        i_point_value  <= pv;
        i_query_mev    <= mev;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(cmd, pe, pv, mev);
        beats_sent++;
    endtask

    // Hold off until the block has answered everything in flight.
    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_clear();
        send_beat(csti_pkg::CMD_CLEAR, csti_pkg::t_energy'($urandom),
                  csti_pkg::t_value'($urandom), t_mev'($urandom));
    endtask

    function automatic csti_pkg::t_value pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return csti_pkg::t_value'($urandom);
        endcase
    endfunction

    function automatic t_mev aim_mev();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_mev'($urandom);
        if (r <= 2 && exact_mev.size() != 0) begin
            return t_mev'(exact_mev[$urandom_range(0, exact_mev.size() - 1)]);
        end
        return t_mev'($urandom_range(lo_mev, hi_mev));
    endfunction

    // Ascending breakpoints, with the odd repeated energy. On the grid every
    // energy is a whole MeV unless clamped at the top of the energy range, so queries can land exactly on breakpoints.
    task automatic load_sorted(int n, int max_step, bit on_grid);
        logic [31:0] e, step;
        int          i;
        if (on_grid) e = $urandom_range(0, 300) * 1000000;
        else         e = $urandom_range(0, 300000000);
        exact_mev.delete();
        lo_mev = int'(e / 1000000);
        for (i = 0; i < n; i++) begin
            if (i != 0) begin
                if ($urandom_range(0, 7) == 0) step = 0;
                else if (on_grid)              step = $urandom_range(1, max_step / 1000000) * 1000000;
                else                           step = $urandom_range(1, max_step);
                e = (e + step > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : e + step;
            end
            if (e % 1000000 == 0 && e / 1000000 <= 1023) begin
                exact_mev = {exact_mev, int'(e / 1000000)};
            end
            send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(e), pick_value(),
                      t_mev'($urandom));
        end
        hi_mev = (e / 1000000 + 1 > 1023) ? 1023 : int'(e / 1000000 + 1);
    endtask

    task automatic load_unsorted(int n);
        int i;
        int mev;
        exact_mev.delete();
        for (i = 0; i < n; i++) begin
            mev = $urandom_range(0, 1023);
            if ($urandom_range(0, 1) == 0) begin
                exact_mev = {exact_mev, mev};
                send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(mev * 1000000),
                          pick_value(), t_mev'($urandom));
            end else begin
                send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'($urandom),
                          pick_value(), t_mev'($urandom));
            end
        end
        lo_mev = 0;
        hi_mev = 1023;
    endtask

    task automatic run_queries(int k);
        repeat (k) begin
            send_beat(csti_pkg::CMD_QUERY, csti_pkg::t_energy'($urandom),
                      csti_pkg::t_value'($urandom), aim_mev());
        end
    endtask

    // Any command, including the unused code, with arbitrary payload.
    task automatic noise_beats(int k);
        repeat (k) begin
            send_beat(csti_pkg::t_cmd'($urandom_range(0, 3)), csti_pkg::t_energy'($urandom),
                      csti_pkg::t_value'($urandom), t_mev'($urandom));
        end
    endtask

    // Fill every slot, push two more points that must bounce with the full
    // status, then run long scans over the whole store.
    task automatic fill_to_capacity();
        pause_until_drained();
        send_clear();
        load_sorted(TBL_DEPTH, 4000000, 1'b0);
        repeat (2) begin
            send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'($urandom),
                      csti_pkg::t_value'($urandom), t_mev'($urandom));
        end
        run_queries(6);
    endtask

    initial begin
        int seq;
        sb = new(TBL_DEPTH);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, no-op code, extremes of energy, value and MeV,
        // falling and rising segments, a repeated energy, queries on the first and
        // last breakpoint, above-range queries and an out-of-order point.
        send_beat(csti_pkg::CMD_QUERY,  '1, '1, t_mev'(5));
        send_beat(CMD_UNUSED,           '1, '1, '1);
        send_beat(csti_pkg::CMD_CLEAR,  '0, '0, '0);
        send_beat(csti_pkg::CMD_APPEND, '0, '1, '0);
        send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(10000000), 32'h0001_0000, '0);
        send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(10000000), 32'h0005_0000, '0);
        send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(500000000), '0, '0);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(0));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(3));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(10));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(200));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(500));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(501));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, '1);
        send_beat(csti_pkg::CMD_APPEND, '1, 32'h8000_0000, '0);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, '1);
        send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(20000000), 32'h1234_5678, '0);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(700));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(15));
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(1));
        send_beat(csti_pkg::CMD_CLEAR,  '1, '1, '1);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(1));
        send_beat(csti_pkg::CMD_APPEND, csti_pkg::t_energy'(1023000000),
                  csti_pkg::t_value'(7), '0);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, '1);
        send_beat(csti_pkg::CMD_QUERY,  '0, '0, t_mev'(1022));

        // Random: mostly clear, load a table, query it. The odd sequence skips
        // the clear and so appends onto whatever is left.
        seq = 0;
        while (beats_sent < ITEM_BEATS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (seq == 3) begin
                fill_to_capacity();
            end else begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3, 4: begin
                        if ($urandom_range(0, 5) != 0) send_clear();
                        load_sorted($urandom_range(1, 10), 150000000, $urandom_range(0, 1));
                        run_queries($urandom_range(2, 8));
                    end
                    5: begin
                        send_clear();
                        load_unsorted($urandom_range(2, 8));
                        run_queries($urandom_range(2, 8));
                    end
                    6: noise_beats($urandom_range(3, 10));
                    default: begin
                        lo_mev = 0;
                        hi_mev = 1023;
                        run_queries($urandom_range(2, 6));
                    end
                endcase
                if ($urandom_range(0, 5) == 0) pause_until_drained();
            end
            seq++;
        end

        start <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ cross_section_table_interpolator.f @@
rtl/csti_pkg.sv
rtl/csti_muldiv.sv
rtl/cross_section_table_interpolator.sv
verif/tb_cross_section_table_interpolator.sv
